>>> hw/rtl/pcm_buffer_dac_feeder_top_assert.svh
// Assertion macros for the PCM buffer DAC feeder.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PCM_BUFFER_DAC_FEEDER_TOP_ASSERT_SVH
`define PCM_BUFFER_DAC_FEEDER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PBDF_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PBDF_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> hw/rtl/pbdf_pkg.sv
`default_nettype none

package pbdf_pkg;

    // Buffer geometry.
    localparam int BUFFER_BYTES = 1024;
    localparam int PTR_W        = $clog2(BUFFER_BYTES);
    localparam int HALF_BYTES   = BUFFER_BYTES / 2;

    // Fixed field widths.
    localparam int WADDR_W = 10;
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 16;
    localparam int CODE_W  = 12;
    localparam int VOL_W   = 8;
    localparam int CFG_W   = 8;
    localparam int CFG_IDX_W = 2;

    // Command codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_IS_16BIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_DIVISOR  = 2'd2;

    localparam logic [1:0] CHANNELS_STEREO = 2'd2;

    // Buffer write request.
    typedef struct packed {
        logic              en;
        logic [PTR_W-1:0]  addr;
        logic [BYTE_W-1:0] data;
    } pbdf_wr_t;

    // Twelve-bit offset-binary code of a sample. The sign flip of the high
    // byte is the same as subtracting 0x80 modulo 256.
    function automatic logic [CODE_W-1:0] sample_code(input logic [BYTE_W-1:0] lo,
                                                      input logic [BYTE_W-1:0] hi,
                                                      input logic is16);
        logic [CODE_W-1:0] code;
        if (is16)
            code = {hi ^ 8'h80, lo[7:4]};
        else
            code = {4'b0000, lo};
        return code;
    endfunction

    // Code times ten as a sum of two shifts; fits 16 bits for 12-bit codes.
    function automatic logic [VALUE_W-1:0] times_ten(input logic [CODE_W-1:0] code);
        logic [VALUE_W-1:0] wide;
        wide = VALUE_W'(code);
        return (wide << 3) + (wide << 1);
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pbdf_buffer.sv
`default_nettype none

module pbdf_buffer
    import pbdf_pkg::*;
(
    input  wire logic              clk,
    input  wire pbdf_wr_t          wr,
    input  wire logic [PTR_W-1:0]  rd_addr,
    output logic      [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [BUFFER_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pbdf_divider.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pbdf_divider
    import pbdf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [VALUE_W-1:0] dividend,
    input  wire logic [VOL_W-1:0]   divisor,
    output logic                    done,
    output logic      [VALUE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(VALUE_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [VOL_W-1:0]   rem_reg;
    logic [VOL_W-1:0]   rem_next;
    logic [VALUE_W-1:0] quo_reg;
    logic [VALUE_W-1:0] quo_next;
    logic [VOL_W-1:0]   div_reg;
    logic [VOL_W:0]     trial;
    logic [VOL_W:0]     diff;
    logic               fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[VALUE_W-1]};
        diff     = trial - {1'b0, div_reg};
        fits     = (trial >= {1'b0, div_reg});
        rem_next = fits ? diff[VOL_W-1:0] : trial[VOL_W-1:0];
        quo_next = {quo_reg[VALUE_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VALUE_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            // A zero divisor acts as one.
            div_reg <= (divisor == '0) ? VOL_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> hw/rtl/pcm_buffer_dac_feeder_top.sv
// PCM buffer DAC feeder.
// The input channel (in_valid/in_ready) carries two kinds of beat. A write
// beat (cmd low) stores write_byte in the 1024-byte sample buffer at
// write_address and gives no result. A tick beat (cmd high) reads one mono
// or stereo sample at the read pointer, scales it by 10/volume_divisor and
// gives one result beat on the output channel (out_valid/out_ready) with the
// left and right DAC words, the alignment flag and the half-buffer flags.
// A tick reads its 1, 2 or 4 bytes through the single buffer read port, with
// an address step and a data step per byte, then runs one or two bit-serial
// divisions (one per channel in stereo) before the result is loaded. Ticks
// are handled one at a time, so the next tick is taken only once the result
// of the last one has been loaded. The result sits in an output register, so
// new write beats are accepted while a result waits; when the receiver stalls,
// a later tick holds at its last step until the pending result is taken.
// Configuration registers (channel_count, sample_is_16bit, volume_divisor)
// are written through cfg_write_enable/cfg_index/cfg_write_data; the user must
// write them only while idle, which the block itself does not enforce.
// Reset clears the read pointer and loads the register defaults; buffer
// contents are undefined until written.
`default_nettype none

module pcm_buffer_dac_feeder_top
    import pbdf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_write_enable,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_write_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 cmd,
    input  wire logic [WADDR_W-1:0]   write_address,
    input  wire logic [BYTE_W-1:0]    write_byte,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [VALUE_W-1:0]   left_value,
    output logic      [VALUE_W-1:0]   right_value,
    output logic                      left_aligned,
    output logic                      half_ready,
    output logic                      half_index
);

    `include "pcm_buffer_dac_feeder_top_assert.svh"

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADDR  = 6'b000010,
        S_DATA  = 6'b000100,
        S_START = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    localparam logic [PTR_W:0] BUF_EXT  = (PTR_W + 1)'(BUFFER_BYTES);
    localparam logic [PTR_W:0] HALF_EXT = (PTR_W + 1)'(HALF_BYTES);

    state_t state_reg;
    state_t state_next;

    // Configuration registers.
    logic [1:0]       chan_reg;
    logic             is16_reg;
    logic [VOL_W-1:0] vol_reg;

    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [1:0]       byte_idx_reg;
    logic             sel_right_reg;
    logic [BYTE_W-1:0] bytes_reg [4];
    logic [VALUE_W-1:0] left_q_reg;

    logic                out_valid_reg;
    logic [VALUE_W-1:0]  left_value_reg;
    logic [VALUE_W-1:0]  right_value_reg;
    logic                left_aligned_reg;
    logic                half_ready_reg;
    logic                half_index_reg;

    logic               stereo;
    logic [1:0]         last_idx;
    logic [2:0]         step;
    logic [PTR_W:0]     addr_sum;
    logic [PTR_W-1:0]   rd_addr;
    logic [BYTE_W-1:0]  rd_data;
    logic [PTR_W:0]     ptr_sum;
    logic               wrap;
    logic               half_hit;
    logic               in_fire;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [VALUE_W-1:0] div_quot;
    logic [VALUE_W-1:0] dividend;
    logic [BYTE_W-1:0]  lo_byte;
    logic [BYTE_W-1:0]  hi_byte;
    pbdf_wr_t           wr;

    assign stereo   = (chan_reg == CHANNELS_STEREO);
    assign last_idx = stereo ? (is16_reg ? 2'd3 : 2'd1) : (is16_reg ? 2'd1 : 2'd0);
    assign step     = {1'b0, last_idx} + 3'd1;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign div_start = (state_reg == S_START);

    // Byte address of the current read, wrapped into the buffer.
    always_comb
    begin
        addr_sum = {1'b0, ptr_reg} + (PTR_W + 1)'(byte_idx_reg);
        if (addr_sum >= BUF_EXT)
            addr_sum = addr_sum - BUF_EXT;
        rd_addr = addr_sum[PTR_W-1:0];
    end

    // Pointer advance and half-buffer flags.
    always_comb
    begin
        ptr_sum  = {1'b0, ptr_reg} + (PTR_W + 1)'(step);
        half_hit = (ptr_sum == HALF_EXT);
        wrap     = (ptr_sum >= BUF_EXT);
        if (wrap)
            ptr_next = PTR_W'(ptr_sum - BUF_EXT);
        else
            ptr_next = ptr_sum[PTR_W-1:0];
    end

    // Dividend for the channel being scaled.
    always_comb
    begin
        if (sel_right_reg)
        begin
            lo_byte = is16_reg ? bytes_reg[2] : bytes_reg[1];
            hi_byte = bytes_reg[3];
        end
        else
        begin
            lo_byte = bytes_reg[0];
            hi_byte = bytes_reg[1];
        end
        dividend = times_ten(sample_code(lo_byte, hi_byte, is16_reg));
    end

    always_comb
    begin
        wr.en   = in_fire && (cmd == CMD_WRITE) && (int'(write_address) < BUFFER_BYTES);
        wr.addr = PTR_W'(write_address);
        wr.data = write_byte;
    end

    pbdf_buffer u_buffer (
        .clk     (clk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pbdf_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (vol_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (cmd == CMD_TICK))
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                state_next = (byte_idx_reg == last_idx) ? S_START : S_ADDR;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = (stereo && !sel_right_reg) ? S_START : S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_reg      <= 2'd1;
            is16_reg      <= 1'b0;
            vol_reg       <= VOL_W'(10);
            ptr_reg       <= '0;
            byte_idx_reg  <= '0;
            sel_right_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write_enable)
            begin
                case (cfg_index)
                    CFG_CHANNEL_COUNT:   chan_reg <= cfg_write_data[1:0];
                    CFG_SAMPLE_IS_16BIT: is16_reg <= cfg_write_data[0];
                    CFG_VOLUME_DIVISOR:  vol_reg  <= cfg_write_data[VOL_W-1:0];
                    default:             ;
                endcase
            end

            if (in_fire && (cmd == CMD_TICK))
            begin
                byte_idx_reg  <= '0;
                sel_right_reg <= 1'b0;
            end
            else if ((state_reg == S_DATA) && (byte_idx_reg != last_idx))
            begin
                byte_idx_reg <= byte_idx_reg + 2'd1;
            end

            if ((state_reg == S_DIV) && div_done)
                sel_right_reg <= 1'b1;

            // A new result may replace the one taken at the same edge.
            if ((state_reg == S_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                ptr_reg       <= ptr_next;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DATA)
            bytes_reg[byte_idx_reg] <= rd_data;

        if ((state_reg == S_DIV) && div_done && !sel_right_reg)
            left_q_reg <= div_quot;

        if ((state_reg == S_OUT) && out_free)
        begin
            left_value_reg   <= left_q_reg;
            // In mono the right word repeats the left word.
            right_value_reg  <= stereo ? div_quot : left_q_reg;
            left_aligned_reg <= is16_reg;
            half_ready_reg   <= wrap || half_hit;
            half_index_reg   <= wrap;
        end
    end

    // The right quotient stays in the divider until the output is loaded.
    assign out_valid    = out_valid_reg;
    assign left_value   = left_value_reg;
    assign right_value  = right_value_reg;
    assign left_aligned = left_aligned_reg;
    assign half_ready   = half_ready_reg;
    assign half_index   = half_index_reg;

    `PBDF_ASSERT_NOW(a_mid_flag_ptr,
        out_valid_reg && half_ready_reg && !half_index_reg,
        ptr_reg == PTR_W'(HALF_BYTES),
        "first-half flag shown while pointer is not at the middle")

    `PBDF_ASSERT_NOW(a_wrap_flag_ptr,
        out_valid_reg && half_ready_reg && half_index_reg,
        ptr_reg < PTR_W'(4),
        "second-half flag shown while pointer has not wrapped")

    `PBDF_ASSERT_NEXT(a_out_load,
        (state_reg == S_OUT) && !out_valid_reg,
        out_valid_reg && (state_reg == S_IDLE),
        "finished tick did not reach the output register")

endmodule

`default_nettype wire

>>> bench/dac_word_checker.sv
// Watches both channels of the PCM buffer DAC feeder, keeps its own copy of
// the sample buffer, the read pointer and the format registers, and compares
// every result beat with the oldest predicted DAC word set.
module dac_word_checker
    import pbdf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_write_enable,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_write_data,

    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 cmd,
    input  logic [WADDR_W-1:0]   write_address,
    input  logic [BYTE_W-1:0]    write_byte,

    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [VALUE_W-1:0]   left_value,
    input  logic [VALUE_W-1:0]   right_value,
    input  logic                 left_aligned,
    input  logic                 half_ready,
    input  logic                 half_index,

    output int                   mismatch_count,
    output int                   words_in_flight,
    output int                   words_checked,
    output int                   half_flags_seen
);

    typedef struct packed {
        logic [VALUE_W-1:0] left;
        logic [VALUE_W-1:0] right;
        logic               aligned;
        logic               half;
        logic               half_idx;
    } dac_word_t;

    // Past this many, mismatches are still counted but no longer printed.
    localparam int PRINT_CAP = 100;

    logic [BYTE_W-1:0] pcm_mem [BUFFER_BYTES];
    logic [PTR_W-1:0]  play_ptr;
    logic [1:0]        chan_cfg;
    logic              wide_cfg;
    logic [VOL_W-1:0]  div_cfg;
    dac_word_t         pending_words [$];

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH at %0t: %s is %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // One scaled DAC word from the sample that starts off bytes past the pointer.
    function automatic logic [VALUE_W-1:0] dac_word(input int unsigned off);
        logic [BYTE_W-1:0] lo;
        logic [BYTE_W-1:0] hi;
        logic [CODE_W-1:0] code;
        int unsigned       divisor;
        int unsigned       scaled;
        lo = pcm_mem[PTR_W'(play_ptr + off)];
        hi = pcm_mem[PTR_W'(play_ptr + off + 1)];
        code = wide_cfg ? {BYTE_W'(hi - 8'h80), lo[7:4]} : CODE_W'(lo);
        divisor = (div_cfg == '0) ? 1 : div_cfg;
        scaled = code;
        scaled = (scaled * 10) / divisor;
        return VALUE_W'(scaled);
    endfunction

    // Consumes one tick: builds the expected words and moves the pointer.
    function automatic dac_word_t play_tick();
        dac_word_t   w;
        int unsigned sample_bytes;
        int unsigned nxt;
        logic        stereo;
        stereo       = (chan_cfg == CHANNELS_STEREO);
        sample_bytes = wide_cfg ? 2 : 1;
        w.left       = dac_word(0);
        w.right      = stereo ? dac_word(sample_bytes) : w.left;
        w.aligned    = wide_cfg;
        w.half       = 1'b0;
        w.half_idx   = 1'b0;
        nxt = play_ptr + (stereo ? 2 * sample_bytes : sample_bytes);
        if (nxt == HALF_BYTES)
            w.half = 1'b1;
        if (nxt >= BUFFER_BYTES)
        begin
            nxt        -= BUFFER_BYTES;
            w.half     = 1'b1;
            w.half_idx = 1'b1;
        end
        play_ptr = PTR_W'(nxt);
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        dac_word_t want;
        if (!rst_n)
        begin
            play_ptr = '0;
            chan_cfg = 2'd1;
            wide_cfg = 1'b0;
            div_cfg  = 8'd10;
            pending_words.delete();
            mismatch_count  = 0;
            words_checked   = 0;
            half_flags_seen = 0;
            words_in_flight <= 0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                case (cfg_index)
                    CFG_CHANNEL_COUNT:   chan_cfg = cfg_write_data[1:0];
                    CFG_SAMPLE_IS_16BIT: wide_cfg = cfg_write_data[0];
                    CFG_VOLUME_DIVISOR:  div_cfg  = cfg_write_data[VOL_W-1:0];
                    default: ;
                endcase
            end

            // A result always belongs to an earlier tick, so it is matched
            // before a tick taken at the same edge is queued.
            if (out_valid && out_ready)
            begin
                if (pending_words.size() == 0)
                    report_mismatch("result beat with no tick waiting, left_value",
                                    left_value, '0);
                else
                begin
                    want = pending_words.pop_front();
                    if (left_value !== want.left)
                        report_mismatch("left_value", left_value, want.left);
                    if (right_value !== want.right)
                        report_mismatch("right_value", right_value, want.right);
                    if (left_aligned !== want.aligned)
                        report_mismatch("left_aligned", left_aligned, want.aligned);
                    if (half_ready !== want.half)
                        report_mismatch("half_ready", half_ready, want.half);
                    if (half_index !== want.half_idx)
                        report_mismatch("half_index", half_index, want.half_idx);
                    words_checked++;
                    if (want.half)
                        half_flags_seen++;
                end
            end

            if (in_valid && in_ready)
            begin
                // The address field cannot exceed the buffer, so every write lands.
                if (cmd == CMD_WRITE)
                    pcm_mem[write_address] = write_byte;
                else
                    pending_words.push_back(play_tick());
            end

            words_in_flight <= pending_words.size();
        end
    end

endmodule

>>> bench/tb_pcm_buffer_dac_feeder_top.sv
// Testbench top for the PCM buffer DAC feeder. This module only produces
// stimulus and gives the verdict; all prediction and comparison lives in the
// checker instance that sits beside the block and watches its channels.
module tb_pcm_buffer_dac_feeder_top;
    import pbdf_pkg::*;

    // Long enough for the slowest tick, stereo 16-bit, so this covers the
    // longest time the block can still be busy after its last result.
    localparam int          DRAIN_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned RANDOM_ITEMS = 950;

    localparam logic [1:0]           CHANNELS_MONO = 2'd1;
    // Register index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;

    logic                 cfg_write_enable;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_write_data;

    logic                 in_valid;
    logic                 in_ready;
    logic                 cmd;
    logic [WADDR_W-1:0]   write_address;
    logic [BYTE_W-1:0]    write_byte;

    logic                 out_valid;
    logic                 out_ready;
    logic [VALUE_W-1:0]   left_value;
    logic [VALUE_W-1:0]   right_value;
    logic                 left_aligned;
    logic                 half_ready;
    logic                 half_index;

    int                   mismatch_count;
    int                   words_in_flight;
    int                   words_checked;
    int                   half_flags_seen;

    // Stimulus-side bookkeeping. The block must never be made to read a
    // buffer byte that was not written, so the top follows the read pointer
    // and remembers which bytes hold data. It predicts nothing about results.
    bit                   fill_map [BUFFER_BYTES];
    int unsigned          play_pos     = 0;
    int unsigned          laps_done    = 0;
    logic [1:0]           fmt_channels = CHANNELS_MONO;
    logic                 fmt_16bit    = 1'b0;

    int unsigned          writes_sent  = 0;
    int unsigned          ticks_sent   = 0;
    int unsigned          formats_run  = 0;
    int unsigned          cycle_count  = 0;

    // When set, the sender or the receiver runs without any idle cycles.
    bit                   in_burst     = 1'b0;
    bit                   out_burst    = 1'b0;

    pcm_buffer_dac_feeder_top u_dut (.*);

    dac_word_checker u_checker (.*);

    always #10 clk = ~clk;

    // Hard stop in case the block hangs or a result never shows up.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Cycle limit reached with %0d results still outstanding.",
                     words_in_flight);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Number of buffer bytes one tick consumes in the current format.
    function automatic int unsigned bytes_per_tick();
        return (fmt_16bit ? 2 : 1) * ((fmt_channels == CHANNELS_STEREO) ? 2 : 1);
    endfunction

    // True when every byte the next tick reads has been written.
    function automatic bit tick_reads_filled();
        int unsigned k;
        for (k = 0; k < bytes_per_tick(); k++)
            if (!fill_map[(play_pos + k) % BUFFER_BYTES])
                return 1'b0;
        return 1'b1;
    endfunction

    // Sends one beat on the input channel. A random number of idle cycles
    // comes first; with no idle cycles, valid simply stays high from the
    // previous beat, so it is never dropped and raised within one step.
    // The task returns in the time step of the edge that accepted the beat.
    task automatic send_beat(input logic kind, input logic [WADDR_W-1:0] addr,
                             input logic [BYTE_W-1:0] data);
        int unsigned gap;
        gap = in_burst ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= kind;
        write_address <= addr;
        write_byte    <= data;
        do
            @(posedge clk);
        while (!in_ready);

        if (kind == CMD_WRITE)
        begin
            fill_map[addr] = 1'b1;
            writes_sent++;
        end
        else
        begin
            play_pos += bytes_per_tick();
            if (play_pos >= BUFFER_BYTES)
            begin
                play_pos -= BUFFER_BYTES;
                laps_done++;
            end
            ticks_sent++;
        end
    endtask

    // Drops valid, waits for every outstanding result, then lets the block
    // run out any work that gives no result. Registers are written only
    // after this. The first edge makes the checker's count of the last
    // accepted beat visible before it is looked at.
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_in_flight != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the three format registers on back-to-back cycles, optionally
    // followed by a write to the unused index. The enable stays high across
    // the series and drops once at the end.
    task automatic program_format(input logic [1:0] chans, input logic w16,
                                  input logic [VOL_W-1:0] div, input bit poke_spare);
        cfg_write_enable <= 1'b1;
        cfg_index        <= CFG_CHANNEL_COUNT;
        cfg_write_data   <= CFG_W'(chans);
        @(posedge clk);
        cfg_index        <= CFG_SAMPLE_IS_16BIT;
        cfg_write_data   <= CFG_W'(w16);
        @(posedge clk);
        cfg_index        <= CFG_VOLUME_DIVISOR;
        cfg_write_data   <= CFG_W'(div);
        @(posedge clk);
        if (poke_spare)
        begin
            cfg_index      <= CFG_SPARE;
            cfg_write_data <= CFG_W'($urandom);
            @(posedge clk);
        end
        cfg_write_enable <= 1'b0;
        fmt_channels = chans;
        fmt_16bit    = w16;
        formats_run++;
    endtask

    // One random stretch of traffic. Most of it follows real use of the
    // ping-pong buffer: refill the bytes the next few ticks will consume
    // (sometimes overwriting old data with fresh bytes), then play them.
    // The rest is scattered writes anywhere in the buffer, or bare ticks
    // that replay whatever is already there.
    task automatic play_sequence();
        int unsigned      n;
        int unsigned      pick;
        int unsigned      k;
        logic [PTR_W-1:0] a;
        pick     = $urandom_range(0, 99);
        in_burst = ($urandom_range(0, 7) == 0);
        if (pick < 75)
        begin
            n = $urandom_range(1, 12);
            for (k = 0; k < n * bytes_per_tick(); k++)
            begin
                a = PTR_W'((play_pos + k) % BUFFER_BYTES);
                if (!fill_map[a] || $urandom_range(0, 7) == 0)
                    send_beat(CMD_WRITE, a, BYTE_W'($urandom));
            end
            repeat (n) send_beat(CMD_TICK, WADDR_W'($urandom), BYTE_W'($urandom));
        end
        else if (pick < 90)
        begin
            repeat ($urandom_range(1, 6))
                send_beat(CMD_WRITE, WADDR_W'($urandom), BYTE_W'($urandom));
        end
        else
        begin
            n = $urandom_range(1, 8);
            while (n != 0 && tick_reads_filled())
            begin
                send_beat(CMD_TICK, WADDR_W'($urandom), BYTE_W'($urandom));
                n--;
            end
        end
    endtask

    // Receiver: for every result beat it draws a random stall of idle cycles,
    // and now and then switches to a stretch with no stalls at all. With no
    // stall, ready just stays high from the previous beat.
    initial
    begin : result_sink
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 32 == 0)
                out_burst = ($urandom_range(0, 3) == 0);
            stall = out_burst ? 0 : $urandom_range(0, 15);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    initial
    begin : stimulus
        int unsigned      random_start;
        int unsigned      phase_end;
        logic [1:0]       chans;
        logic             w16;
        logic [VOL_W-1:0] div;

        // Every input is known from time zero, and reset is held once, at the start
        // of the run.
        rst_n            <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_index        <= CFG_CHANNEL_COUNT;
        cfg_write_data   <= '0;
        in_valid         <= 1'b0;
        cmd              <= CMD_WRITE;
        write_address    <= '0;
        write_byte       <= '0;
        out_ready        <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset format, mono 8-bit with divisor 10: the largest and the
        // smallest byte, and a write to the last address of the buffer.
        send_beat(CMD_WRITE, 10'd0, 8'hFF);
        send_beat(CMD_WRITE, 10'd1, 8'h00);
        send_beat(CMD_WRITE, 10'd1023, 8'hFF);
        send_beat(CMD_TICK, 10'h3FF, 8'h00);
        send_beat(CMD_TICK, 10'h000, 8'hFF);

        // Stereo 16-bit with divisor 1: the full-scale code on the left
        // (the largest possible word) and code zero on the right.
        settle_block();
        program_format(CHANNELS_STEREO, 1'b1, 8'd1, 1'b0);
        send_beat(CMD_WRITE, 10'd2, 8'hFF);
        send_beat(CMD_WRITE, 10'd3, 8'h7F);
        send_beat(CMD_WRITE, 10'd4, 8'h0F);
        send_beat(CMD_WRITE, 10'd5, 8'h80);
        send_beat(CMD_TICK, 10'h155, 8'hAA);

        // Mono 16-bit with the largest divisor; a zero sample sits at
        // mid-scale in offset binary.
        settle_block();
        program_format(CHANNELS_MONO, 1'b1, 8'd255, 1'b0);
        send_beat(CMD_WRITE, 10'd6, 8'h00);
        send_beat(CMD_WRITE, 10'd7, 8'h00);
        send_beat(CMD_TICK, 10'h2AA, 8'h55);

        // Channel count 3 must behave as mono and divisor 0 as 1; the unused
        // register index is written here as well.
        settle_block();
        program_format(2'd3, 1'b0, 8'd0, 1'b1);
        send_beat(CMD_WRITE, 10'd8, 8'hFF);
        send_beat(CMD_TICK, 10'h0F0, 8'h0F);

        // Random phases, each with its own format. Wide formats are favored
        // so the pointer travels as far through the buffer as the run
        // allows; the formats change while the pointer sits anywhere, so
        // later ticks also run misaligned and step across the middle.
        // Stimulus stops once enough items went out.
        random_start = writes_sent + ticks_sent;
        while (writes_sent + ticks_sent - random_start < RANDOM_ITEMS)
        begin
            settle_block();
            chans = $urandom_range(0, 1) ? CHANNELS_STEREO : 2'($urandom_range(0, 3));
            w16   = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 7))
                0:       div = 8'd0;
                1:       div = 8'd1;
                2:       div = 8'd255;
                default: div = VOL_W'($urandom_range(2, 254));
            endcase
            program_format(chans, w16, div, $urandom_range(0, 3) == 0);
            phase_end = writes_sent + ticks_sent + $urandom_range(60, 180);
            if (phase_end > random_start + RANDOM_ITEMS)
                phase_end = random_start + RANDOM_ITEMS;
            while (writes_sent + ticks_sent < phase_end)
                play_sequence();
        end

        settle_block();

        $display("Sent %0d buffer writes and %0d ticks over %0d sample formats.",
                 writes_sent, ticks_sent, formats_run);
        $display("Checked %0d results, %0d with a half-buffer flag; pointer wrapped %0d times.",
                 words_checked, half_flags_seen, laps_done);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
